FILE: src/lrukv_pkg.sv
// ----------------------------------------------------------------------------
// LRU key/value cache package
// Shared sizes, transaction types and command codes.
// ----------------------------------------------------------------------------
package lrukv_pkg;

   // Number of entries in the fully associative store
   localparam int ENTRIES = 16;

   // Field widths
   localparam int KEY_W = 16;
   localparam int VAL_W = 32;
   localparam int CAP_W = 5;

   // Recency rank and fill count widths follow from the entry count
   localparam int AGE_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W = $clog2(ENTRIES + 1);
   // Common width for count versus capacity compares
   localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   // Capacity after reset
   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

   // Command codes
   localparam logic CMD_GET = 1'b0;
   localparam logic CMD_PUT = 1'b1;

   typedef logic [AGE_W-1:0] age_type;
   typedef logic [CNT_W-1:0] cnt_type;
   typedef logic [CMP_W-1:0] cmp_type;

   // Request transaction
   typedef struct packed {
      logic             command;
      logic [KEY_W-1:0] key;
      logic [VAL_W-1:0] value;
   } req_type;

   // Response transaction
   typedef struct packed {
      logic             hit;
      logic [VAL_W-1:0] read_value;
   } rsp_type;

endpackage

FILE: src/lrukv_store.sv
// ----------------------------------------------------------------------------
// LRU key/value store
// Entry arrays with parallel key match, recency ranks and replacement.
// ----------------------------------------------------------------------------
module lrukv_store
   import lrukv_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  req_type              req,
   input  logic [CAP_W-1:0]     capacity,
   output rsp_type              rsp
);

   logic [KEY_W-1:0] key_ff   [ENTRIES];
   logic [VAL_W-1:0] value_ff [ENTRIES];
   age_type          age_ff   [ENTRIES];
   age_type          age_in   [ENTRIES];
   logic [ENTRIES-1:0] valid_ff, valid_in;
   cnt_type            used_ff, used_in;

   logic [ENTRIES-1:0] match;
   logic [ENTRIES-1:0] victim;
   logic [ENTRIES-1:0] valid_post;
   logic [ENTRIES-1:0] free_mask;
   logic [ENTRIES-1:0] ins_slot;
   logic               hit;
   age_type            hit_age;
   logic [VAL_W-1:0]   hit_value;
   cmp_type            cap_eff;
   cmp_type            used_ext;
   cnt_type            used_m1;
   logic               is_put;
   logic               evict;
   logic               insert;

   // Effective capacity: zero counts as one, saturates at the entry count
   always_comb begin
      if (capacity == '0) begin
         cap_eff = CMP_W'(1);
      end else if (CMP_W'(capacity) > CMP_W'(ENTRIES)) begin
         cap_eff = CMP_W'(ENTRIES);
      end else begin
         cap_eff = CMP_W'(capacity);
      end
   end

   assign used_ext = CMP_W'(used_ff);
   assign used_m1  = used_ff - cnt_type'(1);
   assign is_put   = (req.command == CMD_PUT);

   // Parallel lookup; valid keys are unique so match is one-hot or empty
   always_comb begin
      hit_age   = '0;
      hit_value = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         match[i] = valid_ff[i] && (key_ff[i] == req.key);
         if (match[i]) begin
            hit_age   = hit_age | age_ff[i];
            hit_value = hit_value | value_ff[i];
         end
      end
   end

   assign hit    = |match;
   assign evict  = is_put && !hit && (used_ext >= cap_eff);
   assign insert = is_put && !hit;

   // Victim is the valid entry holding the oldest rank (ranks are dense)
   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         victim[i] = evict && valid_ff[i] && (cnt_type'(age_ff[i]) == used_m1);
      end
   end

   // Lowest free slot after eviction, as a one-hot mask
   assign valid_post = valid_ff & ~victim;
   assign free_mask  = ~valid_post;
   assign ins_slot   = insert ? (free_mask & (~free_mask + ENTRIES'(1))) : '0;

   // Next ranks and valid bits
   always_comb begin
      valid_in = valid_ff;
      used_in  = used_ff;
      for (int i = 0; i < ENTRIES; i++) begin
         age_in[i] = age_ff[i];
      end
      if (fire) begin
         if (hit) begin
            // Refresh: younger entries age by one, the touched one goes to rank 0
            for (int i = 0; i < ENTRIES; i++) begin
               if (match[i]) begin
                  age_in[i] = '0;
               end else if (valid_ff[i] && (age_ff[i] < hit_age)) begin
                  age_in[i] = age_ff[i] + age_type'(1);
               end
            end
         end else if (insert) begin
            // Insert: every surviving entry ages by one, the new one is rank 0
            for (int i = 0; i < ENTRIES; i++) begin
               if (ins_slot[i]) begin
                  age_in[i]   = '0;
                  valid_in[i] = 1'b1;
               end else if (victim[i]) begin
                  age_in[i]   = '0;
                  valid_in[i] = 1'b0;
               end else if (valid_post[i]) begin
                  age_in[i] = age_ff[i] + age_type'(1);
               end
            end
            if (!evict) begin
               used_in = used_ff + cnt_type'(1);
            end
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         used_ff  <= '0;
         for (int i = 0; i < ENTRIES; i++) begin
            age_ff[i] <= '0;
         end
      end else begin
         valid_ff <= valid_in;
         used_ff  <= used_in;
         for (int i = 0; i < ENTRIES; i++) begin
            age_ff[i] <= age_in[i];
         end
      end
   end

   // Key and value storage, no reset
   always_ff @(posedge clock) begin
      for (int i = 0; i < ENTRIES; i++) begin
         if (fire && is_put && (match[i] || ins_slot[i])) begin
            value_ff[i] <= req.value;
         end
         if (fire && ins_slot[i]) begin
            key_ff[i] <= req.key;
         end
      end
   end

   // Response: value only on a get hit
   assign rsp.hit        = hit;
   assign rsp.read_value = (hit && !is_put) ? hit_value : '0;

endmodule

FILE: src/lru_key_value_cache_core.sv
// ----------------------------------------------------------------------------
// LRU key/value cache core
// Fully associative get/put cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Accepts one transaction per cycle when the response side does not stall and
// returns one response per request from a registered response output. A
// request is held in an input register; the key compare over all entries,
// the rank update and the replacement choice happen in one pass from that
// register into the response register, so the next request already sees the
// updated store. The capacity register (reset 16; zero acts as one, values
// above the entry count saturate) should be written only while idle.
// ----------------------------------------------------------------------------
module lru_key_value_cache_core
   import lrukv_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   // Request channel
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   // Response channel
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data,
   // Configuration
   input  logic             csr_wr_en,
   input  logic [CAP_W-1:0] csr_wr_data
);

   logic             s1_valid_ff, s1_valid_in;
   req_type          s1_ff, s1_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;
   logic [CAP_W-1:0] cap_ff, cap_in;
   logic             out_free;
   logic             fire;
   rsp_type          store_rsp;

   // Pipeline advance: response register empty or being drained
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign fire      = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_in        = s1_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      cap_in       = cap_ff;
      if (!req_stall) begin
         s1_valid_in = req_valid;
         s1_in       = req_data;
      end
      if (out_free) begin
         rsp_valid_in = s1_valid_ff;
         rsp_in       = store_rsp;
      end
      if (csr_wr_en) begin
         cap_in = csr_wr_data;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cap_ff       <= CAP_RESET;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cap_ff       <= cap_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      s1_ff  <= s1_in;
      rsp_ff <= rsp_in;
   end

   lrukv_store u_store (
      .clock    (clock),
      .reset    (reset),
      .fire     (fire),
      .req      (s1_ff),
      .capacity (cap_ff),
      .rsp      (store_rsp)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // A new response only appears after a held request moved forward
   a_rsp_from_req: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_valid_ff))
      else $error("response appeared without a held request");

   // A stalled request stays in the input register unchanged
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      req_stall |=> s1_valid_ff && $stable(s1_ff))
      else $error("stalled request was lost or changed");

   // The store is updated only when the response register can take the result
   a_fire_ok: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid_ff)
      else $error("processed request produced no response");

endmodule
